/* rtl/core/gbfc_pkg.sv */
// gbfc_pkg: shared constants for the greedy budget fit counter
// default widths, epoch tag width and configuration register map
// no dependencies
package gbfc_pkg;

    localparam int VALUE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 18;
    localparam int BUDGET_BITS    = 28;
    localparam int EPOCH_BITS     = 8;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [PADDR_BITS-3:0] REG_BUDGET = '0;

endpackage

/* rtl/core/greedy_budget_fit_counter.sv */
// greedy_budget_fit_counter: top level with sequencer and node store
// depends on gbfc_pkg
//
// one item in on the s_axis channel: tdata holds item_value, tuser holds new_sequence
// one result out on the m_axis channel: tdata holds drop_count
// budget_limit is written through the apb port at byte address 0 (word index 0)
// each item walks the value-indexed tree top down once for the query, reading one
// left child per level from a node memory with separate read and write ports, may
// finish with a restoring divide at the leaf, one bit a cycle,
// and then updates the VALUE_BITS nodes on its leaf-to-root path
// an item whose value exceeds the budget skips the query walk, and once the item
// counter is full no nodes are updated; the result is loaded before the node update
// s_axis_tready is high only while the sequencer is idle; one item at a time
// a result waits in the output register; a stalled receiver holds the sequencer
// only when the next result is ready and the register is still full
// after reset a clearing pass writes all 2^(VALUE_BITS+1) nodes, one a cycle,
// with s_axis_tready low; a new sequence bumps an epoch tag so stale nodes read
// as zero, and the same pass runs again when the tag wraps, every 2^EPOCH_BITS
// sequence starts; budget_limit resets to zero
module greedy_budget_fit_counter
    import gbfc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IN_W      = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // item_value
    input  logic                  s_axis_tuser,   // new_sequence
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // drop_count
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    localparam int VB       = VALUE_BITS;
    localparam int CB       = COUNT_BITS;
    localparam int NB       = VB + 1;
    localparam int SB       = VB + CB;
    localparam int BB       = BUDGET_BITS;
    localparam int EB       = EPOCH_BITS;
    localparam int WB       = EB + CB + SB;
    localparam int CMP_BITS = (SB > BB) ? SB : BB;
    localparam int DCB      = $clog2(BB);
    localparam int NODES    = 1 << NB;

    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
    localparam logic [EB-1:0] EPOCH_MAX = {EB{1'b1}};
    localparam logic [NB-1:0] ROOT      = NB'(1);
    localparam logic [DCB-1:0] DIV_LAST = DCB'(BB - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_INIT,
        S_QCHK,
        S_QLEFT,
        S_DIV,
        S_RES,
        S_IRD,
        S_IWR
    } state_t;

    state_t          state_reg, state_next;
    logic [VB-1:0]   val_reg, val_next;
    logic            seq_reg, seq_next;
    logic            pend_reg, pend_next;
    logic [EB-1:0]   epoch_reg, epoch_next;
    logic [CB-1:0]   items_reg, items_next;
    logic [SB-1:0]   root_sum_reg, root_sum_next;
    logic [NB-1:0]   node_reg, node_next;
    logic [SB-1:0]   cur_sum_reg, cur_sum_next;
    logic [CB-1:0]   cur_cnt_reg, cur_cnt_next;
    logic [BB-1:0]   lim_reg, lim_next;
    logic [CB-1:0]   kept_reg, kept_next;
    logic [VB-1:0]   rem_reg, rem_next;
    logic [DCB-1:0]  div_cnt_reg, div_cnt_next;
    logic [NB-1:0]   clr_addr_reg, clr_addr_next;
    logic            out_valid_reg, out_valid_next;
    logic [CB-1:0]   out_data_reg, out_data_next;
    logic [BB-1:0]   budget_reg, budget_next;

    logic [WB-1:0]   mem [NODES];
    logic [WB-1:0]   rd_data_reg;
    logic [NB-1:0]   rd_addr;
    logic            wr_en;
    logic [NB-1:0]   wr_addr;
    logic [WB-1:0]   wr_data;

    logic            rd_fresh;
    logic [SB-1:0]   rd_sum;
    logic [CB-1:0]   rd_cnt;
    logic [BB:0]     lim_diff;
    logic            lim_ge_cur;
    logic            lim_le_rd;
    logic [VB:0]     div_trial;
    logic            div_take;
    logic [BB-1:0]   quot;
    logic [CB-1:0]   fit;
    logic [CB-1:0]   kept_clip;
    logic            can_load;
    logic            cfg_wr;

    // node store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_fresh = (rd_data_reg[WB-1:SB+CB] == epoch_reg);
    assign rd_sum   = rd_fresh ? rd_data_reg[SB-1:0] : '0;
    assign rd_cnt   = rd_fresh ? rd_data_reg[SB+CB-1:SB] : '0;

    assign rd_addr = (state_reg == S_QCHK) ? {node_reg[NB-2:0], 1'b0} : node_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = {epoch_reg, rd_cnt + CB'(1), rd_sum + SB'(val_reg)};
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_IWR)
        begin
            wr_en = 1'b1;
        end
    end

    // shared compare, subtract and divide step
    assign lim_diff   = {1'b0, budget_reg} - (BB + 1)'(val_reg);
    assign lim_ge_cur = CMP_BITS'(lim_reg) >= CMP_BITS'(cur_sum_reg);
    assign lim_le_rd  = CMP_BITS'(lim_reg) <= CMP_BITS'(rd_sum);
    assign div_trial  = {rem_reg, lim_reg[BB-1]};
    assign div_take   = div_trial >= {1'b0, node_reg[VB-1:0]};
    assign quot       = {lim_reg[BB-2:0], div_take};
    assign fit        = (quot > BB'(cur_cnt_reg)) ? cur_cnt_reg : CB'(quot);
    assign kept_clip  = (kept_reg > items_reg) ? items_reg : kept_reg;
    assign can_load   = !out_valid_reg || m_axis_tready;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_BITS-1:2] == REG_BUDGET);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_BITS-1:2] == REG_BUDGET) ? PDATA_BITS'(budget_reg) : '0;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        seq_next       = seq_reg;
        pend_next      = pend_reg;
        epoch_next     = epoch_reg;
        items_next     = items_reg;
        root_sum_next  = root_sum_reg;
        node_next      = node_reg;
        cur_sum_next   = cur_sum_reg;
        cur_cnt_next   = cur_cnt_reg;
        lim_next       = lim_reg;
        kept_next      = kept_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        budget_next    = cfg_wr ? pwdata[BB-1:0] : budget_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + NB'(1);
                if (clr_addr_reg == {NB{1'b1}})
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_INIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    val_next   = s_axis_tdata[VB-1:0];
                    seq_next   = s_axis_tuser;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_INIT;
                if (seq_reg)
                begin
                    items_next    = '0;
                    root_sum_next = '0;
                    epoch_next    = epoch_reg + EB'(1);
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        pend_next     = 1'b1;
                        clr_addr_next = '0;
                        state_next    = S_CLEAR;
                    end
                end
            end
            S_INIT:
            begin
                kept_next    = '0;
                node_next    = ROOT;
                cur_sum_next = root_sum_reg;
                cur_cnt_next = items_reg;
                lim_next     = lim_diff[BB-1:0];
                state_next   = lim_diff[BB] ? S_RES : S_QCHK;
            end
            S_QCHK:
            begin
                if (lim_ge_cur)
                begin
                    kept_next  = kept_reg + cur_cnt_reg;
                    state_next = S_RES;
                end
                else if (node_reg[VB])
                begin
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = (node_reg[VB-1:0] == '0) ? S_RES : S_DIV;
                end
                else
                begin
                    state_next = S_QLEFT;
                end
            end
            S_QLEFT:
            begin
                if (lim_le_rd)
                begin
                    node_next    = {node_reg[NB-2:0], 1'b0};
                    cur_sum_next = rd_sum;
                    cur_cnt_next = rd_cnt;
                end
                else
                begin
                    node_next    = {node_reg[NB-2:0], 1'b1};
                    cur_sum_next = cur_sum_reg - rd_sum;
                    cur_cnt_next = cur_cnt_reg - rd_cnt;
                    kept_next    = kept_reg + rd_cnt;
                    lim_next     = BB'(CMP_BITS'(lim_reg) - CMP_BITS'(rd_sum));
                end
                state_next = S_QCHK;
            end
            S_DIV:
            begin
                rem_next     = div_take ? VB'(div_trial - {1'b0, node_reg[VB-1:0]})
                                        : div_trial[VB-1:0];
                lim_next     = quot;
                div_cnt_next = div_cnt_reg + DCB'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    kept_next  = kept_reg + fit;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = items_reg - kept_clip;
                    if (items_reg != COUNT_MAX)
                    begin
                        items_next    = items_reg + CB'(1);
                        root_sum_next = root_sum_reg + SB'(val_reg);
                        node_next     = {1'b1, val_reg};
                        state_next    = S_IRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IRD:
            begin
                state_next = S_IWR;
            end
            S_IWR:
            begin
                node_next  = node_reg >> 1;
                state_next = ((node_reg >> 1) == ROOT) ? S_IDLE : S_IRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            val_reg       <= '0;
            seq_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            epoch_reg     <= '0;
            items_reg     <= '0;
            root_sum_reg  <= '0;
            node_reg      <= ROOT;
            cur_sum_reg   <= '0;
            cur_cnt_reg   <= '0;
            lim_reg       <= '0;
            kept_reg      <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            budget_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            val_reg       <= val_next;
            seq_reg       <= seq_next;
            pend_reg      <= pend_next;
            epoch_reg     <= epoch_next;
            items_reg     <= items_next;
            root_sum_reg  <= root_sum_next;
            node_reg      <= node_next;
            cur_sum_reg   <= cur_sum_next;
            cur_cnt_reg   <= cur_cnt_next;
            lim_reg       <= lim_next;
            kept_reg      <= kept_next;
            rem_reg       <= rem_next;
            div_cnt_reg   <= div_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            budget_reg    <= budget_next;
        end
    end

endmodule

/* rtl/core/gbfc_checker.sv */
// gbfc_checker: port-level assertions for greedy_budget_fit_counter
// depends on gbfc_pkg; bound to the top level at the end of this file
module gbfc_checker
    import gbfc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IN_W      = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((COUNT_BITS + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,   // item_value
    input logic             s_axis_tuser,   // new_sequence
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata    // drop_count
);

    logic last_seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            last_seq_reg <= s_axis_tuser && (s_axis_tdata == s_axis_tdata);
        end
    end

    // a result waiting on a stalled receiver holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // busy right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

    // first item of a sequence drops nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && last_seq_reg |-> m_axis_tdata == '0)
    else $error("nonzero drop on sequence start");

    // clearing pass keeps the input closed right after reset
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !s_axis_tready)
    else $error("input open during clearing pass");

endmodule

bind greedy_budget_fit_counter gbfc_checker #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_gbfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_greedy_budget_fit_counter.sv */
// testbench for greedy_budget_fit_counter: items go in on s_axis, drop counts are checked on m_axis
// against a histogram-based greedy predictor; budget written over apb; depends on gbfc_pkg
`timescale 1ns / 100ps

module tb_greedy_budget_fit_counter;
    import gbfc_pkg::*;

    localparam int IN_W      = ((VALUE_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_W     = ((COUNT_BITS_DEF + 7) / 8) * 8;
    localparam int LEAVES    = 1 << VALUE_BITS_DEF;
    localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS_DEF) - 1;
    localparam logic [PADDR_BITS-1:0] ADDR_BUDGET = {REG_BUDGET, 2'b00};
    localparam logic [PADDR_BITS-1:0] ADDR_SPARE  = ADDR_BUDGET + 3'd4;
    localparam logic [PDATA_BITS-1:0] BUDGET_MAX  = (1 << BUDGET_BITS) - 1;

    class fit_board;
        int unsigned               value_hist [LEAVES];
        longint                    items_seen;
        logic [BUDGET_BITS-1:0]    budget;
        logic [COUNT_BITS_DEF-1:0] drop_due [$];
        int unsigned               errors;

        function new();
            foreach (value_hist[i]) value_hist[i] = 0;
            items_seen = 0;
            budget     = '0;
            errors     = 0;
        endfunction

        // smallest stored values first, partial take at the first value that no longer fits
        function longint count_kept(longint rem);
            longint kept;
            longint take;
            kept = 0;
            if (rem < 0)
                return 0;
            for (int v = 0; v < LEAVES; v++)
            begin
                if (value_hist[v] == 0)
                    continue;
                if (v == 0)
                    take = value_hist[v];
                else
                begin
                    take = rem / v;
                    if (take > value_hist[v])
                        take = value_hist[v];
                end
                kept += take;
                rem  -= take * v;
                if (take < value_hist[v])
                    break;
            end
            return kept;
        endfunction

        function void note_item(logic [VALUE_BITS_DEF-1:0] value, logic new_seq);
            longint kept;
            if (new_seq)
            begin
                foreach (value_hist[i]) value_hist[i] = 0;
                items_seen = 0;
            end
            kept = count_kept(longint'(budget) - longint'(value));
            if (kept > items_seen)
                kept = items_seen;
            drop_due.push_back(COUNT_BITS_DEF'((items_seen - kept) & COUNT_MAX));
            if (items_seen < COUNT_MAX)
            begin
                value_hist[value]++;
                items_seen++;
            end
        endfunction

        function void check_drop(logic [COUNT_BITS_DEF-1:0] got);
            logic [COUNT_BITS_DEF-1:0] want;
            if (drop_due.size() == 0)
            begin
                $display("%0t: drop_count %0d with nothing expected", $time, got);
                errors++;
                return;
            end
            want = drop_due.pop_front();
            if (got !== want)
            begin
                $display("%0t: drop_count expected %0d got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // item_value
    logic                  s_axis_tuser = 1'b0; // new_sequence
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // drop_count
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [PDATA_BITS-1:0] pwdata = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    fit_board    board;
    int unsigned burst_left = 0;
    bit          tx_steady = 1'b0;
    int unsigned rx_hold = 0;
    bit          rx_ready = 1'b0;

    greedy_budget_fit_counter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // receiver: alternating ready and stall stretches, now and then a long clear run
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_ready = !rx_ready;
            if (rx_ready)
                rx_hold = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            else
                rx_hold = $urandom_range(1, 12);
        end
        else
            rx_hold--;
        m_axis_tready <= rx_ready;
    end

    always @(posedge clk)
    begin
        if (board != null && m_axis_tvalid && m_axis_tready)
            board.check_drop(m_axis_tdata[COUNT_BITS_DEF-1:0]);
    end

    task automatic send_item(input logic [VALUE_BITS_DEF-1:0] value, input logic new_seq);
        int unsigned gap;
        gap = 0;
        if (!tx_steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(value);
        s_axis_tuser  <= new_seq;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_item(value, new_seq);
    endtask

    // wait for every result and for the block to be idle again
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.drop_due.size() != 0 || !s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_BITS-1:0] addr, input logic [PDATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_BUDGET)
            board.budget = data[BUDGET_BITS-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [VALUE_BITS_DEF-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return VALUE_BITS_DEF'($urandom_range(1, 15));
        else if (kind < 8)
            return VALUE_BITS_DEF'($urandom_range(1, LEAVES - 1));
        else if (kind == 8)
            return VALUE_BITS_DEF'(($urandom_range(0, 1) == 1) ? LEAVES - 1 : 1);
        else
            return VALUE_BITS_DEF'($urandom_range(0, LEAVES - 1));
    endfunction

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned      seq_span;
        int unsigned      n_items;
        logic [PDATA_BITS-1:0] budget_word;

        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass after reset
        do
            @(posedge clk);
        while (!s_axis_tready);

        // budget zero: every value overshoots
        write_reg(ADDR_BUDGET, '0);
        send_item(10'd1023, 1'b1);
        send_item(10'd1, 1'b0);
        send_item(10'd512, 1'b0);
        drain();

        // all-ones write, masked to the widest budget; unused register
        write_reg(ADDR_BUDGET, '1);
        write_reg(ADDR_SPARE, $urandom());
        send_item(10'd1023, 1'b1);
        send_item(10'd1023, 1'b0);
        send_item(10'd1, 1'b0);
        drain();

        // partly fitting leaf of equal values, zero values, overshoot
        write_reg(ADDR_BUDGET, 32'd10);
        send_item(10'd3, 1'b1);
        send_item(10'd3, 1'b0);
        send_item(10'd3, 1'b0);
        send_item(10'd3, 1'b0);
        send_item(10'd2, 1'b0);
        send_item(10'd1, 1'b0);
        send_item(10'd11, 1'b0);
        send_item(10'd0, 1'b0);
        send_item(10'd0, 1'b0);
        send_item(10'd10, 1'b0);
        drain();

        write_reg(ADDR_BUDGET, 32'd1023);
        send_item(10'd0, 1'b1);
        send_item(10'd0, 1'b0);
        send_item(10'd1023, 1'b0);
        send_item(10'd1, 1'b0);
        send_item(10'd1, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: budget_word = (phase == 0) ? '0 : BUDGET_MAX;
                1: budget_word = $urandom_range(1, 4000);
                2: budget_word = $urandom_range(4000, 200000);
                default: budget_word = $urandom();
            endcase
            write_reg(ADDR_BUDGET, budget_word);
            tx_steady = (phase % 3 == 2);
            // one phase of very short sequences, each item starting a new one with even odds, to bump the epoch tag
            if (phase == 5)
            begin
                seq_span = 1;
                n_items  = 400;
            end
            else
            begin
                seq_span = (phase % 2 == 0) ? 40 : 300;
                n_items  = 90;
            end
            for (int i = 0; i < n_items; i++)
            begin
                send_item(pick_value(), (i == 0) || ($urandom_range(0, seq_span) == 0));
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.drop_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
